>>> hdl/mlt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlt_pkg: shared types and constants
// Payload structs, operation codes and register indexes of the MAC table.
// ---------------------------------------------------------------------------
package mlt_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_AGE        = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AGING_INTERVAL = 8'd1;

    localparam logic [15:0] MAX_AGE_RESET        = 16'd300;
    localparam logic [7:0]  AGING_INTERVAL_RESET = 8'd5;

    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_FLOOD   = 2'd1;
    localparam logic [1:0] ACT_FORWARD = 2'd2;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [63:0] switch_id;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] in_port;
        logic        is_ethernet;
    } req_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] out_port;
        logic        learn_dropped;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_IGNORE,
        OP_PACKET,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] switch_id;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] in_port;
    } qitem_t;

    // Table entry word: key, port and time stamp.
    typedef struct packed {
        logic [63:0] switch_id;
        logic [47:0] mac;
        logic [31:0] port;
        logic [31:0] stamp;
    } entry_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_DRAIN,
        B_WRITE,
        B_RESULT
    } bstate_t;

endpackage

>>> hdl/mlt_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlt_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module mlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/mlt_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlt_front: input acceptance and classification
// Classifies each request as tick, packet or ignored and queues it in a
// two-entry queue for the table engine.
// ---------------------------------------------------------------------------
module mlt_front
    import mlt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_ready,
    input  req_t   req,
    output logic   q_valid,
    input  logic   q_ready,
    output qitem_t q_item
);

    qitem_t     slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    qitem_t     cls;
    logic       push, pop;

    always_comb
    begin
        cls.switch_id = req.switch_id;
        cls.src_mac   = req.src_mac;
        cls.dst_mac   = req.dst_mac;
        cls.in_port   = req.in_port;
        if (req.cmd == CMD_TICK)
        begin
            cls.op = OP_TICK;
        end
        else if (req.is_ethernet && (req.in_port != 32'd0))
        begin
            cls.op = OP_PACKET;
        end
        else
        begin
            cls.op = OP_IGNORE;
        end
    end

    assign req_ready = (count_reg != 2'd2);
    assign q_valid   = (count_reg != 2'd0);
    assign q_item    = slot_reg[rd_ptr_reg];
    assign push      = req_valid && req_ready;
    assign pop       = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/mlt_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlt_back: table engine
// Scans the entry RAM for learning, lookup and aging, writes entries back
// and holds the response register and the configuration registers.
// ---------------------------------------------------------------------------
module mlt_back
    import mlt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  qitem_t                q_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    bstate_t            state_reg, state_next;
    qitem_t             item_reg;
    logic               sweep_mode_reg, sweep_mode_next;
    logic               sweep_pend_reg, sweep_pend_next;
    logic [IDX_W-1:0]   cnt_reg;
    logic               rd_pend_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic               src_hit_reg, free_found_reg, dst_hit_reg;
    logic [IDX_W-1:0]   src_idx_reg, free_idx_reg;
    logic [31:0]        dst_port_reg;
    logic [31:0]        now_reg;
    logic [7:0]         countdown_reg;
    logic [15:0]        max_age_reg;
    logic [7:0]         interval_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg, res_reg;

    entry_t             rd_entry, wr_entry;
    logic               take, issue, load_rsp, do_write;
    logic [IDX_W-1:0]   wr_idx;
    logic [7:0]         count_inc, interval_eff;
    logic               sweep_now;
    logic               src_match, dst_match, old_entry, cur_valid;
    logic               same_key;

    mlt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (do_write),
        .wr_addr (wr_idx),
        .wr_data (wr_entry),
        .rd_en   (issue),
        .rd_addr (cnt_reg),
        .rd_data (rd_entry)
    );

    assign cfg_ready = 1'b1;
    assign q_ready   = (state_reg == B_IDLE) && !sweep_pend_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign take         = q_valid && q_ready;
    assign count_inc    = countdown_reg + 8'd1;
    assign interval_eff = (interval_reg == 8'd0) ? 8'd1 : interval_reg;
    assign sweep_now    = (count_inc >= interval_eff);

    assign cur_valid = valid_reg[rd_idx_reg];
    assign src_match = (rd_entry.mac == item_reg.src_mac)
                    && (rd_entry.switch_id == item_reg.switch_id);
    assign dst_match = (rd_entry.mac == item_reg.dst_mac)
                    && (rd_entry.switch_id == item_reg.switch_id);
    assign old_entry = ({1'b0, rd_entry.stamp} + {17'd0, max_age_reg}) < {1'b0, now_reg};
    assign same_key  = (item_reg.src_mac == item_reg.dst_mac);

    assign wr_idx            = src_hit_reg ? src_idx_reg : free_idx_reg;
    assign do_write          = (state_reg == B_WRITE) && (src_hit_reg || free_found_reg);
    assign wr_entry.switch_id = item_reg.switch_id;
    assign wr_entry.mac      = item_reg.src_mac;
    assign wr_entry.port     = item_reg.in_port;
    assign wr_entry.stamp    = now_reg;

    always_comb
    begin
        state_next      = state_reg;
        sweep_mode_next = sweep_mode_reg;
        sweep_pend_next = sweep_pend_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (sweep_pend_reg)
                begin
                    sweep_pend_next = 1'b0;
                    sweep_mode_next = 1'b1;
                    state_next      = B_SCAN;
                end
                else if (take)
                begin
                    if (q_item.op == OP_PACKET)
                    begin
                        sweep_mode_next = 1'b0;
                        state_next      = B_SCAN;
                    end
                    else
                    begin
                        sweep_pend_next = (q_item.op == OP_TICK) && sweep_now;
                        state_next      = B_RESULT;
                    end
                end
            end
            B_SCAN:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = B_DRAIN;
                end
            end
            B_DRAIN:
            begin
                state_next = sweep_mode_reg ? B_IDLE : B_WRITE;
            end
            B_WRITE:
            begin
                state_next = B_RESULT;
            end
            B_RESULT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        issue    = (state_reg == B_SCAN);
        load_rsp = (state_reg == B_RESULT) && (!rsp_valid_reg || rsp_ready);
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= q_item;
        end
        if (take && (q_item.op != OP_PACKET))
        begin
            res_reg <= '{action: ACT_NONE, out_port: 32'd0, learn_dropped: 1'b0};
        end
        else if (state_reg == B_WRITE)
        begin
            res_reg.learn_dropped <= !src_hit_reg && !free_found_reg;
            if (same_key && (src_hit_reg || free_found_reg))
            begin
                res_reg.action   <= ACT_FORWARD;
                res_reg.out_port <= item_reg.in_port;
            end
            else if (dst_hit_reg)
            begin
                res_reg.action   <= ACT_FORWARD;
                res_reg.out_port <= dst_port_reg;
            end
            else
            begin
                res_reg.action   <= ACT_FLOOD;
                res_reg.out_port <= 32'd0;
            end
        end
        if (load_rsp)
        begin
            rsp_reg <= res_reg;
        end
        if (rd_pend_reg && !sweep_mode_reg && cur_valid)
        begin
            if (src_match)
            begin
                src_idx_reg <= rd_idx_reg;
            end
            if (dst_match)
            begin
                dst_port_reg <= rd_entry.port;
            end
        end
        if (rd_pend_reg && !sweep_mode_reg && !cur_valid && !free_found_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        rd_idx_reg <= cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            sweep_mode_reg <= 1'b0;
            sweep_pend_reg <= 1'b0;
            cnt_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            valid_reg      <= '0;
            src_hit_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            dst_hit_reg    <= 1'b0;
            now_reg        <= 32'd0;
            countdown_reg  <= 8'd0;
            max_age_reg    <= MAX_AGE_RESET;
            interval_reg   <= AGING_INTERVAL_RESET;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_mode_reg <= sweep_mode_next;
            sweep_pend_reg <= sweep_pend_next;
            rd_pend_reg    <= issue;
            if (issue)
            begin
                cnt_reg <= (cnt_reg == LAST_IDX) ? '0 : cnt_reg + IDX_W'(1);
            end
            if (take)
            begin
                src_hit_reg    <= 1'b0;
                free_found_reg <= 1'b0;
                dst_hit_reg    <= 1'b0;
                if (q_item.op == OP_TICK)
                begin
                    now_reg       <= now_reg + 32'd1;
                    countdown_reg <= sweep_now ? 8'd0 : count_inc;
                end
            end
            if (rd_pend_reg && cur_valid)
            begin
                if (sweep_mode_reg)
                begin
                    if (old_entry)
                    begin
                        valid_reg[rd_idx_reg] <= 1'b0;
                    end
                end
                else
                begin
                    if (src_match)
                    begin
                        src_hit_reg <= 1'b1;
                    end
                    if (dst_match)
                    begin
                        dst_hit_reg <= 1'b1;
                    end
                end
            end
            if (rd_pend_reg && !sweep_mode_reg && !cur_valid)
            begin
                free_found_reg <= 1'b1;
            end
            if (do_write && !src_hit_reg)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MAX_AGE:        max_age_reg  <= cfg_data;
                    REG_AGING_INTERVAL: interval_reg <= cfg_data[7:0];
                    default:            ;
                endcase
            end
        end
    end

endmodule

>>> hdl/mac_learning_table_with_aging.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mac_learning_table_with_aging: layer-2 learning table with aging
// Learns source addresses per switch, answers forward or flood for the
// destination and removes stale entries on a periodic sweep.
// ---------------------------------------------------------------------------
//  channel | signals                                    | role
//  req     | req_valid, req_ready, req                  | packet or tick in
//  rsp     | rsp_valid, rsp_ready, rsp                  | one result per transaction
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | register writes
//
// A packet scans the entry RAM read port one entry a cycle, then writes the
// learned entry back. Ticks and ignored packets go straight to the result
// state; a tick that starts a sweep then holds the engine for a full scan.
// Reset clears the valid bits at once; there is no clearing pass.
// A two-entry queue accepts requests while the engine works or the response
// register waits.
module mac_learning_table_with_aging
    import mlt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic   q_valid, q_ready;
    qitem_t q_item;

    mlt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item)
    );

    mlt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // The engine works on one transaction at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_ready |=> !q_ready)
        else $error("engine took a second item while busy");

    // A stalled response stays valid and unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // A full input queue always offers an item to the engine.
    a_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> q_valid)
        else $error("queue blocked while empty");

endmodule

>>> test/mac_learning_table_with_aging_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mac_learning_table_with_aging_tb: self-checking bench for the MAC table
// Drives packets and ticks with random gaps and stalls, predicts every
// response with a behavioral copy of the table and compares in order.
// ---------------------------------------------------------------------------
module mac_learning_table_with_aging_tb;
    import mlt_pkg::*;

    localparam int ENTRIES = 64;

    class mac_table_scoreboard;
        bit          valid_q[ENTRIES];
        logic [47:0] mac_q[ENTRIES];
        logic [63:0] sw_q[ENTRIES];
        logic [31:0] port_q[ENTRIES];
        logic [31:0] stamp_q[ENTRIES];
        logic [31:0] now;
        logic [7:0]  countdown;
        logic [15:0] max_age;
        logic [7:0]  interval;
        rsp_t        pending[$];
        int          errors;

        function void clear();
            foreach (valid_q[i]) valid_q[i] = 0;
            now = 0;
            countdown = 0;
            max_age = MAX_AGE_RESET;
            interval = AGING_INTERVAL_RESET;
            errors = 0;
        endfunction

        function int lookup(logic [47:0] mac, logic [63:0] sw);
            for (int i = 0; i < ENTRIES; i++)
                if (valid_q[i] && mac_q[i] == mac && sw_q[i] == sw)
                    return i;
            return -1;
        endfunction

        function void note_request(req_t r);
            rsp_t  res;
            int    hit;
            int    d;
            logic [7:0] lim;
            logic [32:0] sum;
            res = '0;
            res.action = ACT_NONE;
            if (r.cmd == CMD_TICK) begin
                lim = (interval == 8'd0) ? 8'd1 : interval;
                now = now + 32'd1;
                countdown = countdown + 8'd1;
                if (countdown >= lim) begin
                    countdown = 8'd0;
                    for (int i = 0; i < ENTRIES; i++) begin
                        sum = {1'b0, stamp_q[i]} + {17'b0, max_age};
                        if (valid_q[i] && sum < {1'b0, now})
                            valid_q[i] = 0;
                    end
                end
            end else if (r.is_ethernet && r.in_port != 32'd0) begin
                hit = lookup(r.src_mac, r.switch_id);
                if (hit < 0) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (!valid_q[i]) begin
                            hit = i;
                            break;
                        end
                    if (hit >= 0) begin
                        valid_q[hit] = 1;
                        mac_q[hit] = r.src_mac;
                        sw_q[hit] = r.switch_id;
                    end else
                        res.learn_dropped = 1'b1;
                end
                if (hit >= 0) begin
                    port_q[hit] = r.in_port;
                    stamp_q[hit] = now;
                end
                d = lookup(r.dst_mac, r.switch_id);
                if (d >= 0) begin
                    res.action = ACT_FORWARD;
                    res.out_port = port_q[d];
                end else
                    res.action = ACT_FLOOD;
            end
            pending.push_back(res);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected response %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.action !== want.action) begin
                $display("%0t: action expected %0d actual %0d", $time, want.action, got.action);
                errors++;
            end
            if (got.out_port !== want.out_port) begin
                $display("%0t: out_port expected %0d actual %0d", $time, want.out_port,
                         got.out_port);
                errors++;
            end
            if (got.learn_dropped !== want.learn_dropped) begin
                $display("%0t: learn_dropped expected %0b actual %0b", $time,
                         want.learn_dropped, got.learn_dropped);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic req_valid = 0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 0;
    rsp_t rsp;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    mac_table_scoreboard table_model;
    int  hold_off_cycles = 0;
    bit  drain_free = 0;

    // Small pools of addresses and switches so that lookups hit often.
    logic [47:0] mac_pool[12];
    logic [63:0] sw_pool[3];

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    mac_learning_table_with_aging dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 2);
    endfunction

    // Response side: sample at the rising edge, change ready at the falling one.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            table_model.check_response(rsp);
    end

    initial
    begin
        int n;
        @(negedge clk);
        forever
        begin
            if (hold_off_cycles > 0) begin
                rsp_ready <= 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            rsp_ready <= 1'b1;
            @(negedge clk);
            if (!drain_free && $urandom_range(0, 3) == 0) begin
                n = gap_length();
                if (n > 0) begin
                    rsp_ready <= 1'b0;
                    repeat (n) @(negedge clk);
                end
            end
        end
    end

    // Valid stays high from one transaction to the next unless a gap follows.
    task automatic send_request(req_t r, bit gaps);
        int n;
        if (gaps && $urandom_range(0, 2) == 0) begin
            n = gap_length();
            if (n > 0) begin
                req_valid <= 1'b0;
                repeat (n) @(negedge clk);
            end
        end
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        table_model.note_request(r);
        @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_MAX_AGE)
            table_model.max_age = val;
        else if (idx == REG_AGING_INTERVAL)
            table_model.interval = val[7:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (table_model.pending.size() != 0) @(negedge clk);
        // A tick may still be sweeping after its response left.
        repeat (ENTRIES + 10) @(negedge clk);
    endtask

    function automatic req_t make_packet(logic [63:0] sw, logic [47:0] src,
                                         logic [47:0] dst, logic [31:0] port, logic eth);
        req_t r;
        r.cmd = CMD_PACKET;
        r.switch_id = sw;
        r.src_mac = src;
        r.dst_mac = dst;
        r.in_port = port;
        r.is_ethernet = eth;
        return r;
    endfunction

    function automatic req_t make_tick();
        req_t r;
        r = '0;
        r.cmd = CMD_TICK;
        r.switch_id = {$urandom, $urandom};
        r.src_mac = 48'({$urandom, $urandom});
        r.dst_mac = 48'({$urandom, $urandom});
        r.in_port = $urandom;
        r.is_ethernet = 1'($urandom);
        return r;
    endfunction

    function automatic req_t random_item(bit fill);
        int k;
        k = $urandom_range(0, 99);
        if (k < 20)
            return make_tick();
        if (k < 26)
            return make_packet({$urandom, $urandom}, 48'({$urandom, $urandom}),
                               48'({$urandom, $urandom}), $urandom, 1'($urandom));
        if (k < 30)
            return make_packet(sw_pool[$urandom_range(0, 2)], mac_pool[$urandom_range(0, 11)],
                               mac_pool[$urandom_range(0, 11)],
                               ($urandom_range(0, 1) ? 32'd0 : $urandom),
                               1'($urandom_range(0, 1)));
        if (fill && k < 60)
            return make_packet(sw_pool[$urandom_range(0, 2)], 48'({$urandom, $urandom}),
                               mac_pool[$urandom_range(0, 11)], $urandom | 32'd1, 1'b1);
        return make_packet(sw_pool[$urandom_range(0, 2)], mac_pool[$urandom_range(0, 11)],
                           mac_pool[$urandom_range(0, 11)], $urandom_range(1, 255) |
                           ($urandom_range(0, 7) == 0 ? 32'hFFFF_FF00 : 32'd0), 1'b1);
    endfunction

    task automatic random_phase(int count, bit fill);
        for (int i = 0; i < count; i++)
            send_request(random_item(fill), 1);
    endtask

    initial
    begin
        table_model = new();
        table_model.clear();
        foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom});
        mac_pool[0] = 48'h0;
        mac_pool[1] = 48'hFFFF_FFFF_FFFF;
        sw_pool[0] = 64'h0;
        sw_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        sw_pool[2] = {$urandom, $urandom};
        repeat (7) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: extremes, ignored packets, self lookup, forward, ticks.
        send_request(make_packet(sw_pool[1], mac_pool[1], mac_pool[0], 32'hFFFF_FFFF, 1'b1), 0);
        send_request(make_packet(sw_pool[1], mac_pool[0], mac_pool[1], 32'd1, 1'b1), 0);
        send_request(make_packet(sw_pool[0], mac_pool[2], mac_pool[2], 32'd7, 1'b1), 0);
        send_request(make_packet(sw_pool[0], mac_pool[3], mac_pool[2], 32'd0, 1'b1), 0);
        send_request(make_packet(sw_pool[0], mac_pool[3], mac_pool[2], 32'd9, 1'b0), 0);
        send_request(make_packet(sw_pool[1], mac_pool[2], mac_pool[1], 32'd5, 1'b1), 0);
        send_request(make_packet(sw_pool[0], mac_pool[1], mac_pool[2], 32'd3, 1'b1), 0);
        for (int i = 0; i < 6; i++) send_request(make_tick(), 0);
        wait_drained();

        // Zero max age and zero interval: every tick sweeps everything older.
        write_register(REG_MAX_AGE, 16'd0);
        write_register(REG_AGING_INTERVAL, 16'd0);
        send_request(make_packet(sw_pool[0], mac_pool[4], mac_pool[5], 32'd11, 1'b1), 0);
        send_request(make_tick(), 0);
        send_request(make_packet(sw_pool[0], mac_pool[5], mac_pool[4], 32'd12, 1'b1), 0);
        send_request(make_tick(), 0);
        send_request(make_tick(), 0);
        send_request(make_packet(sw_pool[0], mac_pool[6], mac_pool[5], 32'd13, 1'b1), 0);
        wait_drained();

        // Table fill: many fresh sources, long aging so nothing leaves.
        write_register(REG_MAX_AGE, 16'hFFFF);
        write_register(REG_AGING_INTERVAL, 16'd255);
        random_phase(250, 1);
        wait_drained();

        // Block the response side while requests keep coming.
        write_register(REG_MAX_AGE, 16'd3);
        write_register(REG_AGING_INTERVAL, 16'd1);
        hold_off_cycles = 300;
        random_phase(300, 0);
        drain_free = 1;
        wait_drained();
        drain_free = 0;

        write_register(REG_MAX_AGE, 16'd1);
        write_register(REG_AGING_INTERVAL, 16'd2);
        random_phase(300, 0);
        wait_drained();

        write_register(REG_MAX_AGE, 16'd20);
        write_register(REG_AGING_INTERVAL, 16'd5);
        random_phase(330, 0);
        wait_drained();

        if (table_model.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end
endmodule

>>> files.f
hdl/mlt_pkg.sv
hdl/mlt_ram.sv
hdl/mlt_front.sv
hdl/mlt_back.sv
hdl/mac_learning_table_with_aging.sv
test/mac_learning_table_with_aging_tb.sv
